// ===== rtl/gabb_pkg.sv =====
// Package for the glyph alpha blend blitter: shared constants and types.
// No dependencies.
package gabb_pkg;

  localparam int unsigned StorePixels = 65536;

  localparam logic [1:0] ModeBlend = 2'd0;
  localparam logic [1:0] ModeWrite = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;

  localparam logic [10:0] WidthReset  = 11'd256;
  localparam logic [10:0] HeightReset = 11'd256;
  localparam logic [23:0] ColorReset  = 24'hFFFFFF;

  // A classified request from the front end to the back end.
  typedef struct packed {
    logic [1:0]  mode;
    logic        ok;
    logic [23:0] addr;
    logic [7:0]  cov;
    logic [31:0] pv;
  } req_t;

endpackage

// ===== rtl/gabb_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing.
module gabb_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [23:0] quo_o
);

  logic [23:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] den_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [16:0] trial;

  // One shift and trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, quo_q[23]};
    rem_d = trial[15:0];
    quo_d = {quo_q[22:0], 1'b0};
    if (trial >= {1'b0, den_q}) begin
      rem_d    = 16'(trial - {1'b0, den_q});
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd24;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== rtl/gabb_front.sv =====
// Front end: glyph counters, address forming and clipping.
// Depends on gabb_pkg.
module gabb_front #(
  parameter int unsigned STORE_PIXELS = gabb_pkg::StorePixels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [11:0]       origin_x_i,
  input  logic [11:0]       origin_y_i,
  input  logic [7:0]        glyph_width_i,
  input  logic [7:0]        coverage_i,
  input  logic              last_of_glyph_i,
  input  logic [31:0]       pixel_value_i,
  input  logic [10:0]       surf_w_i,
  input  logic [10:0]       surf_h_i,
  output logic              req_valid_o,
  input  logic              req_ready_i,
  output gabb_pkg::req_t    req_o
);
  import gabb_pkg::*;

  logic [7:0]  col_q, row_q;
  logic [7:0]  col_inc;
  logic [12:0] ry;
  logic [12:0] rx;
  logic [23:0] prod_q, lim_q;
  logic [12:0] rx_q;
  logic [1:0]  mode_q;
  logic [7:0]  cov_q;
  logic [31:0] pv_q;
  logic        st_q;
  logic [24:0] addr;
  logic        ok;
  logic        take;

  // Stage 0 takes the item and multiplies; stage 1 adds, clips and passes on.
  assign in_ready_o = !st_q;
  assign take = in_valid_i && in_ready_o;
  assign ry = (mode_i == ModeBlend) ? 13'(origin_y_i) + 13'(row_q) : 13'(origin_y_i);
  assign rx = (mode_i == ModeBlend) ? 13'(origin_x_i) + 13'(col_q) : 13'(origin_x_i);
  assign col_inc = col_q + 8'd1;
  assign addr = 25'(prod_q) + 25'(rx_q);
  assign ok = (25'(addr) < 25'(lim_q)) && (25'(addr) < 25'(STORE_PIXELS)) &&
              (prod_q[23] == 1'b0) &&
              ((mode_q == ModeBlend) || (mode_q == ModeWrite) || (mode_q == ModeRead));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      st_q  <= 1'b0;
    end else begin
      if (take) begin
        st_q <= 1'b1;
        if (mode_i == ModeBlend) begin
          if (last_of_glyph_i) begin
            col_q <= '0;
            row_q <= '0;
          end else if (col_inc >= glyph_width_i) begin
            col_q <= '0;
            row_q <= row_q + 8'd1;
          end else begin
            col_q <= col_inc;
          end
        end
      end else if (st_q && req_ready_i) begin
        st_q <= 1'b0;
      end
    end
  end

  // Product saturates into bit 23 when it does not fit in 23 bits.
  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_q <= (ry * 25'(surf_w_i)) > 25'h7FFFFF ? 24'h800000
                : 24'(ry * 25'(surf_w_i));
      lim_q  <= 24'(22'(surf_w_i) * 22'(surf_h_i));
      rx_q   <= rx;
      mode_q <= mode_i;
      cov_q  <= coverage_i;
      pv_q   <= pixel_value_i;
    end
  end

  assign req_valid_o  = st_q;
  assign req_o.mode = mode_q;
  assign req_o.ok   = ok;
  assign req_o.addr = addr[23:0];
  assign req_o.cov  = cov_q;
  assign req_o.pv   = pv_q;

endmodule

// ===== rtl/gabb_fifo.sv =====
// Two-entry request queue between front and back end.
// Depends on gabb_pkg.
module gabb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  gabb_pkg::req_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output gabb_pkg::req_t rd_data_o
);
  import gabb_pkg::*;

  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= 2'(cnt_q + 2'(push) - 2'(pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ===== rtl/gabb_back.sv =====
// Back end: frame store read-modify-write and source-over compositing.
// Depends on gabb_pkg and gabb_divider.
module gabb_back #(
  parameter int unsigned STORE_PIXELS = gabb_pkg::StorePixels,
  localparam int unsigned AW = $clog2(STORE_PIXELS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  gabb_pkg::req_t req_i,
  input  logic [23:0]    color_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    read_data_o,
  output logic           in_bounds_o
);
  import gabb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_ALPHA, S_CH, S_CDIV, S_DONE
  } state_e;

  logic [31:0] store_q [STORE_PIXELS];
  state_e      state_q;
  req_t        r_q;
  logic [31:0] dst_q;
  logic [7:0]  a_q;
  logic [1:0]  ch_q;
  logic [23:0] res_q;
  logic [31:0] out_q;
  logic        okout_q, ov_q;
  logic [AW-1:0] ad;
  logic        dv_start;
  logic [23:0] dv_num;
  logic [15:0] dv_den;
  logic        dv_done;
  logic [23:0] dv_quo;
  logic [7:0]  da, isa;
  logic [15:0] tm1_q, tm2_q;
  logic [15:0] amul;
  logic [8:0]  aq255;
  logic [7:0]  alpha;

  assign ad = r_q.addr[AW-1:0];
  assign da = dst_q[31:24];
  assign isa = 8'd255 - r_q.cov;

  // Result alpha; the shift-and-add form is an exact floor division by 255
  // for products up to 255 * 255.
  assign amul  = 16'(da) * 16'(isa);
  assign aq255 = 9'((17'(amul) + 17'd1 + 17'(amul[15:8])) >> 8);
  assign alpha = 8'(9'(r_q.cov) + aq255);

  gabb_divider u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  // Divider operands for each color channel.
  always_comb begin
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = 16'd1;
    if (state_q == S_CH) begin
      dv_start = 1'b1;
      dv_num = 24'(tm1_q) * 24'd255 + 24'(32'(tm2_q) * 32'(isa));
      dv_den = 16'(16'(a_q) * 16'd255);
    end
  end

  assign req_ready_o = state_q == S_IDLE && !ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (req_valid_i && !ov_q) state_q <= S_READ;
        S_READ: begin
          if (!r_q.ok || r_q.mode != ModeBlend) state_q <= S_DONE;
          else state_q <= S_ALPHA;
        end
        S_ALPHA: state_q <= (alpha == 8'd0) ? S_DONE : S_CH;
        S_CH: state_q <= S_CDIV;
        S_CDIV: if (dv_done) state_q <= (ch_q == 2'd2) ? S_DONE : S_CH;
        S_DONE: begin
          ov_q    <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath and store access.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (req_valid_i && !ov_q) r_q <= req_i;
      S_READ: begin
        dst_q <= store_q[ad];
        ch_q  <= '0;
        res_q <= '0;
        okout_q <= r_q.ok;
        if (r_q.ok && r_q.mode == ModeWrite) store_q[ad] <= r_q.pv;
        if (!r_q.ok) out_q <= '0;
        else if (r_q.mode == ModeWrite) out_q <= r_q.pv;
        else if (r_q.mode == ModeRead) out_q <= store_q[ad];
      end
      S_ALPHA: begin
        a_q <= alpha;
        out_q <= '0;
        if (alpha == 8'd0) store_q[ad] <= '0;
      end
      S_CH: ;
      S_CDIV: if (dv_done) begin
        res_q[8*ch_q +: 8] <= dv_quo[7:0];
        ch_q <= ch_q + 2'd1;
        if (ch_q == 2'd2) begin
          out_q <= {a_q, dv_quo[7:0], res_q[15:0]};
          store_q[ad] <= {a_q, dv_quo[7:0], res_q[15:0]};
        end
      end
      S_DONE: ;
      default: ;
    endcase
    if ((state_q == S_ALPHA) || (state_q == S_CDIV && dv_done && ch_q != 2'd2)) begin
      tm1_q <= 16'(color_i[8*((state_q == S_ALPHA) ? 2'd0 : ch_q + 2'd1) +: 8]) * 16'(r_q.cov);
      tm2_q <= 16'(dst_q[8*((state_q == S_ALPHA) ? 2'd0 : ch_q + 2'd1) +: 8]) * 16'(da);
    end
  end

  assign out_valid_o = ov_q;
  assign read_data_o = out_q;
  assign in_bounds_o = okout_q;

endmodule

// ===== rtl/glyph_alpha_blend_blitter_unit.sv =====
// Glyph alpha blend blitter top level: APB registers, front end, queue, back end.
// Depends on gabb_pkg, gabb_front, gabb_fifo and gabb_back.
//
// Usage: coverage bytes (mode 0) are sent in raster order on the in_* channel
// with valid and ready; each yields one result on the out_* channel, the
// blended pixel and an in-bounds flag. Mode 1 writes and mode 2 reads one
// pixel. Registers (width, height, color) are written over APB while idle.
// A blend whose result alpha is not zero waits on the bit-serial divider,
// which runs three 24-step divisions in turn, one per color channel.
// The back end takes its next request only after its result is accepted,
// so it works on one request at a time. The front end cannot take a new
// item until its previous one has passed on, and the queue holds two
// requests, so it keeps accepting while the back end works.
// Reset clears the glyph counters and queue and sets the registers to their
// reset values; the frame store holds garbage until written. When the
// receiver stalls the result stays on the output and the back end waits;
// the queue then fills and ready falls.
module glyph_alpha_blend_blitter_unit #(
  parameter int unsigned STORE_PIXELS = gabb_pkg::StorePixels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [11:0] origin_x_i,
  input  logic [11:0] origin_y_i,
  input  logic [7:0]  glyph_width_i,
  input  logic [7:0]  coverage_i,
  input  logic        last_of_glyph_i,
  input  logic [31:0] pixel_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        in_bounds_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gabb_pkg::*;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegColor  = 2'd2;

  logic [10:0] w_q, h_q;
  logic [23:0] c_q;
  logic        fv, fr, bv, br;
  req_t        freq, breq;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= WidthReset;
      h_q <= HeightReset;
      c_q <= ColorReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      case (paddr[3:2])
        RegWidth:  w_q <= pwdata[10:0];
        RegHeight: h_q <= pwdata[10:0];
        RegColor:  c_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[3:2])
      RegWidth:  prdata = 32'(w_q);
      RegHeight: prdata = 32'(h_q);
      RegColor:  prdata = 32'(c_q);
      default:   prdata = '0;
    endcase
  end

  gabb_front #(.STORE_PIXELS(STORE_PIXELS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .origin_x_i, .origin_y_i,
    .glyph_width_i, .coverage_i, .last_of_glyph_i, .pixel_value_i,
    .surf_w_i(w_q), .surf_h_i(h_q),
    .req_valid_o(fv), .req_ready_i(fr), .req_o(freq)
  );

  gabb_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(freq),
    .rd_valid_o(bv), .rd_ready_i(br), .rd_data_o(breq)
  );

  gabb_back #(.STORE_PIXELS(STORE_PIXELS)) u_back (
    .clk_i, .rst_ni, .req_valid_i(bv), .req_ready_o(br), .req_i(breq),
    .color_i(c_q), .out_valid_o, .out_ready_i, .read_data_o, .in_bounds_o
  );

endmodule

// ===== rtl/gabb_checker.sv =====
// Port-level checker for the blitter, bound to the top level.
// Depends on glyph_alpha_blend_blitter_unit.
module gabb_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_data_o,
  input logic        in_bounds_o,
  input logic        pready
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o))
    else $error("result dropped or changed under stall");

  // Clipped requests return zero data.
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_bounds_o |-> read_data_o == 32'd0)
    else $error("clipped request returned data");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind glyph_alpha_blend_blitter_unit gabb_port_checks u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .read_data_o, .in_bounds_o, .pready
);
